>>> sv/red_drop_decision_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RED drop decision block
// Shared forms for the concurrent checks, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RED_DROP_DECISION_ASSERT_SVH
`define RED_DROP_DECISION_ASSERT_SVH

// Same-cycle implication.
`define RDD_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RDD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rdd_pkg.sv
// ----------------------------------------------------------------------------
// rdd_pkg
// Field widths, codes, sequencer states and interface structs shared by the
// RED drop decision block and its divider.
// ----------------------------------------------------------------------------
package rdd_pkg;

   // Field widths of the request, response and register port.
   localparam int QIDX_WIDTH      = 4;
   localparam int LEN_WIDTH       = 12;
   localparam int AVG_WIDTH       = 20;
   localparam int THR_WIDTH       = 12;
   localparam int PROB_WIDTH      = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int AVG_FRAC_BITS   = 8;
   localparam int SPAN_WIDTH      = THR_WIDTH + AVG_FRAC_BITS;
   localparam int MUL_WIDTH       = AVG_WIDTH + PROB_WIDTH;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   // Packet counter codes.
   localparam logic [COUNT_WIDTH-1:0] COUNT_MINUS_ONE = 16'hFFFF;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP       = 16'h7FFF;

   // Register indexes and reset values.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DROP_PROB = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MARKING_MODE  = 4'd1;
   localparam logic [PROB_WIDTH-1:0]      MAX_DROP_PROB_RESET = 16'd6554;

   typedef enum logic [1:0] {
      ACT_ACCEPT = 2'd0,
      ACT_DROP   = 2'd1,
      ACT_MARK   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CAUSE_BELOW_MIN = 2'd0,
      CAUSE_EARLY     = 2'd1,
      CAUSE_AVG_OVER  = 2'd2,
      CAUSE_LEN_OVER  = 2'd3
   } cause_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_CLASSIFY,
      ST_MUL_PB,
      ST_LOAD_PB,
      ST_WAIT_PB,
      ST_MUL_PROD,
      ST_CHECK,
      ST_WAIT_PA,
      ST_FINISH
   } state_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> sv/rdd_div_unit.sv
// ----------------------------------------------------------------------------
// rdd_div_unit
// Shared restoring divider: one quotient bit per cycle. The caller preloads
// a partial remainder below the divisor and the dividend bits still to come,
// so only the quotient bits that can be nonzero are worked out.
// ----------------------------------------------------------------------------
module rdd_div_unit #(
   parameter int REM_WIDTH  = 20,
   parameter int BITS_WIDTH = 17,
   parameter int STEP_WIDTH = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [REM_WIDTH-1:0]        den,
   input  logic [REM_WIDTH-1:0]        rem_init,
   input  logic [BITS_WIDTH-1:0]       bits_init,
   input  logic [STEP_WIDTH-1:0]       steps,
   output rdd_pkg::div_status_type     status,
   output logic [BITS_WIDTH-1:0]       quotient
);
   import rdd_pkg::*;

   logic [REM_WIDTH-1:0]  den_ff, den_in;
   logic [REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [BITS_WIDTH-1:0] bits_ff, bits_in;
   logic [BITS_WIDTH-1:0] quot_ff, quot_in;
   logic [STEP_WIDTH-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [REM_WIDTH:0]    trial;
   logic [REM_WIDTH:0]    diff;
   logic                  qbit;

   // One trial subtraction per cycle; the borrow decides the quotient bit.
   always_comb begin
      trial   = {rem_ff, bits_ff[BITS_WIDTH-1]};
      diff    = trial - {1'b0, den_ff};
      qbit    = ~diff[REM_WIDTH];
      den_in  = den_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (load) begin
         den_in  = den;
         rem_in  = rem_init;
         bits_in = bits_init;
         quot_in = '0;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
         bits_in = bits_ff << 1;
         quot_in = {quot_ff[BITS_WIDTH-2:0], qbit};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

>>> sv/red_drop_decision.sv
// ----------------------------------------------------------------------------
// red_drop_decision: per-packet RED drop or mark decision
// Outside the early region no division is run; inside it the shared divider runs
// the bit-serial pb division and, unless pa is forced to one, the pa division.
// One word at a time; the next can be taken in the cycle after the word ahead is issued.
// After reset, a clearing pass sets every packet counter to minus one.
// ----------------------------------------------------------------------------
`include "red_drop_decision_assert.svh"

module red_drop_decision #(
   parameter int QUEUE_COUNT        = 16,
   parameter int PROB_FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rdd_pkg::QIDX_WIDTH-1:0]       req_queue_index,
   input  logic [rdd_pkg::LEN_WIDTH-1:0]        req_queue_length,
   input  logic [rdd_pkg::AVG_WIDTH-1:0]        req_average_length,
   input  logic [rdd_pkg::THR_WIDTH-1:0]        req_min_threshold,
   input  logic [rdd_pkg::THR_WIDTH-1:0]        req_max_threshold,
   input  logic [rdd_pkg::PROB_WIDTH-1:0]       req_random_fraction,
   // Response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rdd_pkg::action_type                  rsp_action,
   output rdd_pkg::cause_type                   rsp_cause,
   // Register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rdd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rdd_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import rdd_pkg::*;

   localparam int FRAC_ONE   = 1 << PROB_FRACTION_BITS;
   localparam int PA_WIDTH   = PROB_FRACTION_BITS + 1;
   localparam int REM_WIDTH  = (PA_WIDTH > SPAN_WIDTH) ? PA_WIDTH : SPAN_WIDTH;
   localparam int BITS_WIDTH = (PA_WIDTH > PROB_WIDTH) ? PA_WIDTH : PROB_WIDTH;
   localparam int STEP_WIDTH = $clog2(BITS_WIDTH + 1);
   localparam int CMP_WIDTH  = (PA_WIDTH + 1 > PROB_WIDTH) ? PA_WIDTH + 1 : PROB_WIDTH;
   localparam int ADDR_WIDTH = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int QEXT_WIDTH = ($clog2(QUEUE_COUNT + 1) > QIDX_WIDTH) ?
                               $clog2(QUEUE_COUNT + 1) : QIDX_WIDTH;

   // Sequencer and register state.
   state_type              state_ff, state_in;
   logic [ADDR_WIDTH-1:0]  clr_ff, clr_in;
   logic [QIDX_WIDTH-1:0]  q_ff, q_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic [AVG_WIDTH-1:0]   avg_ff, avg_in;
   logic [THR_WIDTH-1:0]   min_ff, min_in;
   logic [THR_WIDTH-1:0]   max_ff, max_in;
   logic [PROB_WIDTH-1:0]  rnd_ff, rnd_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [PROB_WIDTH-1:0]  pb_ff, pb_in;
   logic [MUL_WIDTH-1:0]   product_ff, product_in;
   logic                   hit_ff, hit_in;
   cause_type              cause_ff, cause_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   action_type             rsp_action_ff, rsp_action_in;
   cause_type              rsp_cause_ff, rsp_cause_in;
   logic [PROB_WIDTH-1:0]  mdp_ff, mdp_in;
   logic                   marking_ff, marking_in;
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   // Counter memory.
   logic [COUNT_WIDTH-1:0] count_mem [QUEUE_COUNT];
   logic                   mem_we;
   logic [ADDR_WIDTH-1:0]  mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic [ADDR_WIDTH-1:0]  mem_raddr;

   // Datapath nets.
   logic [QEXT_WIDTH-1:0]  q_ext;
   logic [AVG_WIDTH-1:0]   min_scaled;
   logic [AVG_WIDTH-1:0]   max_scaled;
   logic [AVG_WIDTH-1:0]   span;
   logic                   in_region;
   logic                   avg_over;
   logic                   len_over;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [AVG_WIDTH-1:0]   mul_a;
   logic [PROB_WIDTH-1:0]  mul_b;
   logic                   prod_sat;
   logic [PA_WIDTH-1:0]    pa_den;
   logic                   ratio_sat;
   logic [BITS_WIDTH-1:0]  pa_val;
   logic                   hit_now;

   // Divider hookup.
   logic                   div_load;
   logic [REM_WIDTH-1:0]   div_den;
   logic [REM_WIDTH-1:0]   div_rem_init;
   logic [BITS_WIDTH-1:0]  div_bits_init;
   logic [STEP_WIDTH-1:0]  div_steps;
   div_status_type         div_status;
   logic [BITS_WIDTH-1:0]  div_quotient;

   rdd_div_unit #(
      .REM_WIDTH  (REM_WIDTH),
      .BITS_WIDTH (BITS_WIDTH),
      .STEP_WIDTH (STEP_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .den       (div_den),
      .rem_init  (div_rem_init),
      .bits_init (div_bits_init),
      .steps     (div_steps),
      .status    (div_status),
      .quotient  (div_quotient)
   );

   // Region tests, counter advance and the shared multiplier operands.
   always_comb begin
      q_ext      = QEXT_WIDTH'(q_ff);
      mem_raddr  = q_ext[ADDR_WIDTH-1:0];
      min_scaled = {min_ff, {AVG_FRAC_BITS{1'b0}}};
      max_scaled = {max_ff, {AVG_FRAC_BITS{1'b0}}};
      span       = max_scaled - min_scaled;
      in_region  = (min_scaled <= avg_ff) && (avg_ff < max_scaled);
      avg_over   = (avg_ff >= max_scaled);
      len_over   = (len_ff >= max_ff);
      if (rd_data_ff == COUNT_MINUS_ONE) begin
         count_next = '0;
      end else if (rd_data_ff < COUNT_TOP) begin
         count_next = rd_data_ff + 1'b1;
      end else begin
         count_next = rd_data_ff;
      end
      if (state_ff == ST_MUL_PB) begin
         mul_a = avg_ff - min_scaled;
         mul_b = mdp_ff;
      end else begin
         mul_a = AVG_WIDTH'(count_ff);
         mul_b = pb_ff;
      end
   end

   // Probability limits and the hit test against the random fraction.
   always_comb begin
      prod_sat  = (product_ff >= MUL_WIDTH'(FRAC_ONE));
      pa_den    = PA_WIDTH'(FRAC_ONE) - product_ff[PA_WIDTH-1:0];
      ratio_sat = (CMP_WIDTH'(pb_ff) >= CMP_WIDTH'({pa_den, 1'b0}));
      if (state_ff == ST_CHECK) begin
         pa_val = BITS_WIDTH'(FRAC_ONE);
      end else if (div_quotient > BITS_WIDTH'(FRAC_ONE)) begin
         pa_val = BITS_WIDTH'(FRAC_ONE);
      end else begin
         pa_val = div_quotient;
      end
      hit_now = (BITS_WIDTH'(rnd_ff) < pa_val);
   end

   // Divider operands: pb = mdp*diff/span first, then pa = pb*ONE/(ONE - count*pb).
   always_comb begin
      if (state_ff == ST_CHECK) begin
         div_den       = REM_WIDTH'(pa_den);
         div_rem_init  = REM_WIDTH'(pb_ff[PROB_WIDTH-1:1]);
         div_bits_init = BITS_WIDTH'(pb_ff[0]) << (BITS_WIDTH - 1);
         div_steps     = STEP_WIDTH'(PA_WIDTH);
      end else begin
         div_den       = REM_WIDTH'(span);
         div_rem_init  = REM_WIDTH'(product_ff[MUL_WIDTH-1:PROB_WIDTH]);
         div_bits_init = BITS_WIDTH'(product_ff[PROB_WIDTH-1:0]) <<
                         (BITS_WIDTH - PROB_WIDTH);
         div_steps     = STEP_WIDTH'(PROB_WIDTH);
      end
   end

   // Sequencer: next state, register updates and memory writes.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      q_in          = q_ff;
      len_in        = len_ff;
      avg_in        = avg_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rnd_in        = rnd_ff;
      count_in      = count_ff;
      pb_in         = pb_ff;
      product_in    = product_ff;
      hit_in        = hit_ff;
      cause_in      = cause_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_action_in = rsp_action_ff;
      rsp_cause_in  = rsp_cause_ff;
      mdp_in        = mdp_ff;
      marking_in    = marking_ff;
      mem_we        = 1'b0;
      mem_waddr     = mem_raddr;
      mem_wdata     = hit_ff ? '0 : count_ff;
      div_load      = 1'b0;
      req_ready     = (state_ff == ST_IDLE);
      csr_ready     = 1'b1;

      // Register writes.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_DROP_PROB: begin
               mdp_in = csr_data[PROB_WIDTH-1:0];
            end
            CSR_MARKING_MODE: begin
               marking_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end

      // The output word leaves when taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if ((state_ff == ST_MUL_PB) || (state_ff == ST_MUL_PROD)) begin
         product_in = MUL_WIDTH'(mul_a) * MUL_WIDTH'(mul_b);
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = COUNT_MINUS_ONE;
            if (clr_ff == ADDR_WIDTH'(QUEUE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               q_in     = req_queue_index;
               len_in   = req_queue_length;
               avg_in   = req_average_length;
               min_in   = req_min_threshold;
               max_in   = req_max_threshold;
               rnd_in   = req_random_fraction;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // Fold the queue index into range, one subtraction a cycle.
            if (q_ext >= QEXT_WIDTH'(QUEUE_COUNT)) begin
               q_in = QIDX_WIDTH'(q_ext - QEXT_WIDTH'(QUEUE_COUNT));
            end else begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (in_region) begin
               count_in = count_next;
               cause_in = CAUSE_EARLY;
               state_in = ST_MUL_PB;
            end else if (avg_over) begin
               count_in = '0;
               hit_in   = 1'b1;
               cause_in = CAUSE_AVG_OVER;
               state_in = ST_FINISH;
            end else if (len_over) begin
               count_in = '0;
               hit_in   = 1'b1;
               cause_in = CAUSE_LEN_OVER;
               state_in = ST_FINISH;
            end else begin
               count_in = COUNT_MINUS_ONE;
               hit_in   = 1'b0;
               cause_in = CAUSE_BELOW_MIN;
               state_in = ST_FINISH;
            end
         end
         ST_MUL_PB: begin
            state_in = ST_LOAD_PB;
         end
         ST_LOAD_PB: begin
            div_load = 1'b1;
            state_in = ST_WAIT_PB;
         end
         ST_WAIT_PB: begin
            if (div_status.done) begin
               pb_in    = div_quotient[PROB_WIDTH-1:0];
               state_in = ST_MUL_PROD;
            end
         end
         ST_MUL_PROD: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // A product at one or a ratio of two or more forces pa to one.
            if (prod_sat || ratio_sat) begin
               hit_in   = hit_now;
               state_in = ST_FINISH;
            end else begin
               div_load = 1'b1;
               state_in = ST_WAIT_PA;
            end
         end
         ST_WAIT_PA: begin
            if (div_status.done) begin
               hit_in   = hit_now;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cause_in  = cause_ff;
               rsp_action_in = hit_ff ? (marking_ff ? ACT_MARK : ACT_DROP) : ACT_ACCEPT;
               mem_we        = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mdp_ff       <= MAX_DROP_PROB_RESET;
         marking_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         mdp_ff       <= mdp_in;
         marking_ff   <= marking_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      len_ff        <= len_in;
      avg_ff        <= avg_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      rnd_ff        <= rnd_in;
      count_ff      <= count_in;
      pb_ff         <= pb_in;
      product_ff    <= product_in;
      hit_ff        <= hit_in;
      cause_ff      <= cause_in;
      rsp_action_ff <= rsp_action_in;
      rsp_cause_ff  <= rsp_cause_in;
   end

   // Counter memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= count_mem[mem_raddr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_cause  = rsp_cause_ff;

   // Checks.
   `RDD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready, "request taken but the block stayed ready")
   `RDD_ASSERT_IMPLIES(a_below_min_accepts, clock, reset,
      rsp_valid && (rsp_cause == CAUSE_BELOW_MIN), rsp_action == ACT_ACCEPT,
      "word below the lower threshold was not accepted")
   `RDD_ASSERT_IMPLIES(a_over_max_hits, clock, reset,
      rsp_valid && (rsp_cause == CAUSE_AVG_OVER || rsp_cause == CAUSE_LEN_OVER),
      rsp_action != ACT_ACCEPT, "word over the upper threshold was accepted")

endmodule
